// ===== rtl/core/slfb_pkg.sv =====
// Shared types, constants, microcode program and helper functions of the LED frame builder.
package slfb_pkg;

  localparam int STRIP_LENGTH = 147;
  localparam int ANGLE_LIMIT  = 402;
  localparam int PIX_LIMIT    = STRIP_LENGTH - 1;
  localparam int DIV          = 2 * ANGLE_LIMIT;
  localparam int NUM_SEGS     = 5;

  localparam int ANGLE_W  = 16;
  localparam int SINCE_W  = 17;
  localparam int TURN_W   = 12;
  localparam int CFG_W    = 16;
  localparam int BYTE_W   = 8;
  localparam int PROD_W   = 18;
  localparam int RECIP_SHIFT = 27;
  localparam int RECIP    = (1 << RECIP_SHIFT) / DIV;
  localparam int RECIP_W  = 18;
  localparam int MULT_W   = PROD_W + RECIP_W;
  localparam int MID_W    = 8;
  localparam int POS_W    = 10;
  localparam int CNT_W    = 4;
  localparam int SEG_W    = $clog2(NUM_SEGS);
  localparam int NSEG_W   = 3;
  localparam int STEP_W   = 5;

  localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};

  localparam logic [BYTE_W-1:0] CH_S = 8'h73;
  localparam logic [BYTE_W-1:0] CH_T = 8'h74;
  localparam logic [BYTE_W-1:0] CH_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_R = 8'h72;

  localparam logic [BYTE_W-1:0] FULL      = 8'd255;
  localparam logic [BYTE_W-1:0] ORANGE_G  = 8'd140;
  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'd0;

  typedef enum logic [1:0] {
    MODE_ANGLE = 2'd0,
    MODE_DIST  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_FRAME = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_DIST_THR  = 2'd0,
    CFG_HOLD_TIME = 2'd1,
    CFG_TURN_THR  = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_COLOR,
    ACT_RECIP,
    ACT_MID,
    ACT_BOUNDS,
    ACT_PIX_LOAD,
    ACT_PIX_STEP,
    ACT_SEG_STEP
  } act_t;

  typedef enum logic [2:0] {
    SRC_LIT,
    SRC_NSEG,
    SRC_RED,
    SRC_GREEN,
    SRC_BLUE,
    SRC_COUNT,
    SRC_PIXEL
  } src_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NOT_FRAME,
    COND_SEG_EMPTY,
    COND_PIX_MORE,
    COND_SEG_MORE
  } cond_t;

  typedef struct packed {
    act_t              act;
    logic              emit;
    src_t              src;
    logic [BYTE_W-1:0] lit;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    uword_t uw;
    logic   go;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic frame;
    logic seg_empty;
    logic pix_more;
    logic seg_more;
  } dp_status_t;

  // program steps
  localparam logic [STEP_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [STEP_W-1:0] ST_COLOR   = 5'd1;
  localparam logic [STEP_W-1:0] ST_RECIP   = 5'd2;
  localparam logic [STEP_W-1:0] ST_MID     = 5'd3;
  localparam logic [STEP_W-1:0] ST_BOUNDS  = 5'd4;
  localparam logic [STEP_W-1:0] ST_CH0     = 5'd5;
  localparam logic [STEP_W-1:0] ST_CH1     = 5'd6;
  localparam logic [STEP_W-1:0] ST_CH2     = 5'd7;
  localparam logic [STEP_W-1:0] ST_CH3     = 5'd8;
  localparam logic [STEP_W-1:0] ST_CH4     = 5'd9;
  localparam logic [STEP_W-1:0] ST_NSEG    = 5'd10;
  localparam logic [STEP_W-1:0] ST_SEG_CHK = 5'd11;
  localparam logic [STEP_W-1:0] ST_RED     = 5'd12;
  localparam logic [STEP_W-1:0] ST_GREEN   = 5'd13;
  localparam logic [STEP_W-1:0] ST_BLUE    = 5'd14;
  localparam logic [STEP_W-1:0] ST_COUNT   = 5'd15;
  localparam logic [STEP_W-1:0] ST_PIXEL   = 5'd16;
  localparam logic [STEP_W-1:0] ST_SEG_NXT = 5'd17;
  localparam logic [STEP_W-1:0] ST_DONE    = 5'd18;

  function automatic uword_t make_word(act_t act, logic emit, src_t src,
                                       logic [BYTE_W-1:0] lit, cond_t cond,
                                       logic [STEP_W-1:0] target);
    uword_t w;
    w.act    = act;
    w.emit   = emit;
    w.src    = src;
    w.lit    = lit;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic uword_t ucode(logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      ST_IDLE:    w = make_word(ACT_ACCEPT, 1'b0, SRC_LIT, ZERO_BYTE, COND_NOT_FRAME, ST_IDLE);
      ST_COLOR:   w = make_word(ACT_COLOR, 1'b0, SRC_LIT, ZERO_BYTE, COND_NEXT, ST_IDLE);
      ST_RECIP:   w = make_word(ACT_RECIP, 1'b0, SRC_LIT, ZERO_BYTE, COND_NEXT, ST_IDLE);
      ST_MID:     w = make_word(ACT_MID, 1'b0, SRC_LIT, ZERO_BYTE, COND_NEXT, ST_IDLE);
      ST_BOUNDS:  w = make_word(ACT_BOUNDS, 1'b0, SRC_LIT, ZERO_BYTE, COND_NEXT, ST_IDLE);
      ST_CH0:     w = make_word(ACT_NONE, 1'b1, SRC_LIT, CH_S, COND_NEXT, ST_IDLE);
      ST_CH1:     w = make_word(ACT_NONE, 1'b1, SRC_LIT, CH_T, COND_NEXT, ST_IDLE);
      ST_CH2:     w = make_word(ACT_NONE, 1'b1, SRC_LIT, CH_A, COND_NEXT, ST_IDLE);
      ST_CH3:     w = make_word(ACT_NONE, 1'b1, SRC_LIT, CH_R, COND_NEXT, ST_IDLE);
      ST_CH4:     w = make_word(ACT_NONE, 1'b1, SRC_LIT, CH_T, COND_NEXT, ST_IDLE);
      ST_NSEG:    w = make_word(ACT_NONE, 1'b1, SRC_NSEG, ZERO_BYTE, COND_NEXT, ST_IDLE);
      ST_SEG_CHK: w = make_word(ACT_NONE, 1'b0, SRC_LIT, ZERO_BYTE, COND_SEG_EMPTY,
                                ST_SEG_NXT);
      ST_RED:     w = make_word(ACT_NONE, 1'b1, SRC_RED, ZERO_BYTE, COND_NEXT, ST_IDLE);
      ST_GREEN:   w = make_word(ACT_NONE, 1'b1, SRC_GREEN, ZERO_BYTE, COND_NEXT, ST_IDLE);
      ST_BLUE:    w = make_word(ACT_NONE, 1'b1, SRC_BLUE, ZERO_BYTE, COND_NEXT, ST_IDLE);
      ST_COUNT:   w = make_word(ACT_PIX_LOAD, 1'b1, SRC_COUNT, ZERO_BYTE, COND_NEXT, ST_IDLE);
      ST_PIXEL:   w = make_word(ACT_PIX_STEP, 1'b1, SRC_PIXEL, ZERO_BYTE, COND_PIX_MORE,
                                ST_PIXEL);
      ST_SEG_NXT: w = make_word(ACT_SEG_STEP, 1'b0, SRC_LIT, ZERO_BYTE, COND_SEG_MORE,
                                ST_SEG_CHK);
      ST_DONE:    w = make_word(ACT_NONE, 1'b0, SRC_LIT, ZERO_BYTE, COND_ALWAYS, ST_IDLE);
      default:    w = make_word(ACT_NONE, 1'b0, SRC_LIT, ZERO_BYTE, COND_ALWAYS, ST_IDLE);
    endcase
    return w;
  endfunction

  // segment spans relative to mid
  function automatic logic signed [POS_W-1:0] seg_lo(int k);
    case (k)
      0:       return POS_W'(-10);
      1:       return POS_W'(-8);
      2:       return POS_W'(-4);
      3:       return POS_W'(4);
      default: return POS_W'(8);
    endcase
  endfunction

  function automatic logic signed [POS_W-1:0] seg_hi(int k);
    case (k)
      0:       return POS_W'(-8);
      1:       return POS_W'(-4);
      2:       return POS_W'(4);
      3:       return POS_W'(8);
      default: return POS_W'(10);
    endcase
  endfunction

  // x/3 and 2x/3 by reciprocal multiply, exact for 8-bit x
  function automatic logic [BYTE_W-1:0] third(logic [BYTE_W-1:0] x);
    logic [15:0] p;
    p = {8'd0, x} * 16'd171;
    return {1'b0, p[15:9]};
  endfunction

  function automatic logic [BYTE_W-1:0] two_thirds(logic [BYTE_W-1:0] x);
    logic [16:0] p;
    p = {8'd0, x, 1'b0} * 17'd171;
    return p[16:9];
  endfunction

  function automatic logic [BYTE_W-1:0] seg_colour(logic [BYTE_W-1:0] x,
                                                   logic [SEG_W-1:0] seg,
                                                   logic [BYTE_W-1:0] centre);
    case (seg)
      SEG_W'(0), SEG_W'(4): return third(x);
      SEG_W'(1), SEG_W'(3): return two_thirds(x);
      default:              return centre;
    endcase
  endfunction

endpackage

// ===== rtl/core/slfb_sequencer.sv =====
// Microcode sequencer: step counter, program ROM lookup and branch logic.
module slfb_sequencer (
  input  logic                   clk,
  input  logic                   rst,
  input  slfb_pkg::dp_status_t   status,
  input  logic                   out_free,
  output slfb_pkg::ctrl_t        ctrl
);

  logic [slfb_pkg::STEP_W-1:0] step;
  logic [slfb_pkg::STEP_W-1:0] step_next;
  slfb_pkg::uword_t            uw;
  logic                        taken;
  logic                        go;

  assign uw = slfb_pkg::ucode(step);

  always_comb begin
    case (uw.act)
      slfb_pkg::ACT_ACCEPT: go = status.in_valid;
      default:              go = !uw.emit || out_free;
    endcase
  end

  always_comb begin
    case (uw.cond)
      slfb_pkg::COND_NEXT:      taken = 1'b0;
      slfb_pkg::COND_ALWAYS:    taken = 1'b1;
      slfb_pkg::COND_NOT_FRAME: taken = !status.frame;
      slfb_pkg::COND_SEG_EMPTY: taken = status.seg_empty;
      slfb_pkg::COND_PIX_MORE:  taken = status.pix_more;
      slfb_pkg::COND_SEG_MORE:  taken = status.seg_more;
      default:                  taken = 1'b1;
    endcase
    step_next = taken ? uw.target : step + slfb_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= slfb_pkg::ST_IDLE;
    end else if (go) begin
      step <= step_next;
    end
  end

  assign ctrl.uw = uw;
  assign ctrl.go = go;

endmodule

// ===== rtl/core/slfb_datapath.sv =====
// Datapath: config registers, event state, colour, mid pixel, segment bounds and byte select.
module slfb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  slfb_pkg::ctrl_t               ctrl,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [1:0]                    s_tuser,
  input  logic [31:0]                   s_tdata,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [slfb_pkg::CFG_W-1:0]    cfg_data,
  output slfb_pkg::dp_status_t          status,
  output logic [slfb_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last
);

  localparam int POS_W = slfb_pkg::POS_W;
  localparam int NUM_SEGS = slfb_pkg::NUM_SEGS;
  localparam logic signed [POS_W-1:0] PIX_LIMIT_S = POS_W'(slfb_pkg::PIX_LIMIT);
  localparam logic signed [slfb_pkg::ANGLE_W-1:0] LIM_POS =
    slfb_pkg::ANGLE_W'(slfb_pkg::ANGLE_LIMIT);
  localparam logic signed [slfb_pkg::ANGLE_W-1:0] LIM_NEG =
    slfb_pkg::ANGLE_W'(-slfb_pkg::ANGLE_LIMIT);

  logic [slfb_pkg::CFG_W-1:0]          dist_thr;
  logic [slfb_pkg::CFG_W-1:0]          hold_time;
  logic [slfb_pkg::TURN_W-1:0]         turn_thr;
  logic signed [slfb_pkg::ANGLE_W-1:0] stored_angle;
  logic                                close_flag;
  logic [slfb_pkg::SINCE_W-1:0]        since_ms;
  logic [slfb_pkg::BYTE_W-1:0]         red;
  logic [slfb_pkg::BYTE_W-1:0]         green;
  logic [slfb_pkg::BYTE_W-1:0]         blue;
  logic [slfb_pkg::PROD_W-1:0]         prod;
  logic [slfb_pkg::MID_W-1:0]          q0;
  logic [slfb_pkg::MID_W-1:0]          mid;
  logic [slfb_pkg::BYTE_W-1:0]         seg_clo [NUM_SEGS];
  logic [slfb_pkg::CNT_W-1:0]          seg_cnt [NUM_SEGS];
  logic [slfb_pkg::NSEG_W-1:0]         nseg;
  logic [slfb_pkg::SEG_W-1:0]          last_seg;
  logic [slfb_pkg::SEG_W-1:0]          seg;
  logic [slfb_pkg::BYTE_W-1:0]         pix;
  logic [slfb_pkg::CNT_W-1:0]          rem;

  slfb_pkg::mode_t                     mode;
  logic                                accept;
  logic                                step_go;
  logic                                close_now;
  logic [slfb_pkg::SINCE_W-1:0]        mag;
  logic [slfb_pkg::SINCE_W-1:0]        angle_ext;
  logic signed [slfb_pkg::ANGLE_W-1:0] clamped;
  logic [slfb_pkg::ANGLE_W-1:0]        diff;
  logic [slfb_pkg::MULT_W-1:0]         recip_prod;
  logic [slfb_pkg::PROD_W-1:0]         mid_rem;
  logic signed [POS_W-1:0]             mid_s;
  logic signed [POS_W-1:0]             b_lo  [NUM_SEGS];
  logic signed [POS_W-1:0]             b_hi  [NUM_SEGS];
  logic signed [POS_W-1:0]             b_clo [NUM_SEGS];
  logic signed [POS_W-1:0]             b_chi [NUM_SEGS];
  logic [slfb_pkg::CNT_W-1:0]          b_cnt [NUM_SEGS];
  logic [slfb_pkg::NSEG_W-1:0]         b_nseg;
  logic [slfb_pkg::SEG_W-1:0]          b_last;

  assign mode     = slfb_pkg::mode_t'(s_tuser);
  assign s_tready = (ctrl.uw.act == slfb_pkg::ACT_ACCEPT);
  assign accept   = s_tready && s_tvalid;
  assign step_go  = ctrl.go;

  // colour, clamp and mid-pixel division terms
  always_comb begin
    close_now = close_flag && !(since_ms > {1'b0, hold_time});
    angle_ext = {stored_angle[slfb_pkg::ANGLE_W-1], stored_angle};
    mag       = stored_angle[slfb_pkg::ANGLE_W-1] ? -angle_ext : angle_ext;
    if (stored_angle > LIM_POS) begin
      clamped = LIM_POS;
    end else if (stored_angle < LIM_NEG) begin
      clamped = LIM_NEG;
    end else begin
      clamped = stored_angle;
    end
    diff       = LIM_POS - clamped;
    recip_prod = slfb_pkg::MULT_W'(prod) * slfb_pkg::MULT_W'(slfb_pkg::RECIP);
    mid_rem    = prod - slfb_pkg::PROD_W'(q0) * slfb_pkg::PROD_W'(slfb_pkg::DIV);
  end

  // clipped segment spans
  always_comb begin
    mid_s  = $signed({2'b00, mid});
    b_nseg = '0;
    b_last = '0;
    for (int k = 0; k < NUM_SEGS; k++) begin
      b_lo[k]  = mid_s + slfb_pkg::seg_lo(k);
      b_hi[k]  = mid_s + slfb_pkg::seg_hi(k);
      b_clo[k] = (b_lo[k] < 0) ? '0 : b_lo[k];
      b_chi[k] = (b_hi[k] > PIX_LIMIT_S) ? PIX_LIMIT_S : b_hi[k];
      b_cnt[k] = (b_chi[k] > b_clo[k]) ? slfb_pkg::CNT_W'(b_chi[k] - b_clo[k]) : '0;
      if (b_cnt[k] != '0) begin
        b_nseg = b_nseg + slfb_pkg::NSEG_W'(1);
        b_last = slfb_pkg::SEG_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_thr     <= slfb_pkg::CFG_W'(1000);
      hold_time    <= slfb_pkg::CFG_W'(1000);
      turn_thr     <= slfb_pkg::TURN_W'(436);
      stored_angle <= '0;
      close_flag   <= 1'b0;
      since_ms     <= slfb_pkg::SINCE_MAX;
    end else begin
      if (cfg_we) begin
        case (slfb_pkg::cfg_idx_t'(cfg_index))
          slfb_pkg::CFG_DIST_THR:  dist_thr  <= cfg_data;
          slfb_pkg::CFG_HOLD_TIME: hold_time <= cfg_data;
          slfb_pkg::CFG_TURN_THR:  turn_thr  <= cfg_data[slfb_pkg::TURN_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        case (mode)
          slfb_pkg::MODE_ANGLE: stored_angle <= $signed(s_tdata[15:0]);
          slfb_pkg::MODE_DIST: begin
            if (s_tdata[31:16] < dist_thr) begin
              close_flag <= 1'b1;
              since_ms   <= '0;
            end
          end
          slfb_pkg::MODE_TICK: begin
            if (since_ms != slfb_pkg::SINCE_MAX) begin
              since_ms <= since_ms + slfb_pkg::SINCE_W'(1);
            end
          end
          default: ;
        endcase
      end
      if (step_go && ctrl.uw.act == slfb_pkg::ACT_COLOR) begin
        close_flag   <= close_now;
        stored_angle <= clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      case (ctrl.uw.act)
        slfb_pkg::ACT_COLOR: begin
          if (close_now) begin
            red <= slfb_pkg::FULL; green <= slfb_pkg::ZERO_BYTE; blue <= slfb_pkg::ZERO_BYTE;
          end else if (mag > {5'd0, turn_thr}) begin
            red <= slfb_pkg::FULL; green <= slfb_pkg::ORANGE_G; blue <= slfb_pkg::ZERO_BYTE;
          end else begin
            red <= slfb_pkg::ZERO_BYTE; green <= slfb_pkg::FULL; blue <= slfb_pkg::ZERO_BYTE;
          end
          prod <= slfb_pkg::PROD_W'(slfb_pkg::STRIP_LENGTH) * slfb_pkg::PROD_W'(diff);
        end
        slfb_pkg::ACT_RECIP: q0 <= recip_prod[slfb_pkg::RECIP_SHIFT +: slfb_pkg::MID_W];
        slfb_pkg::ACT_MID: begin
          // reciprocal quotient is at most one low
          mid <= (mid_rem >= slfb_pkg::PROD_W'(slfb_pkg::DIV)) ?
                 q0 + slfb_pkg::MID_W'(1) : q0;
        end
        slfb_pkg::ACT_BOUNDS: begin
          for (int k = 0; k < NUM_SEGS; k++) begin
            seg_clo[k] <= b_clo[k][slfb_pkg::BYTE_W-1:0];
            seg_cnt[k] <= b_cnt[k];
          end
          nseg     <= b_nseg;
          last_seg <= b_last;
          seg      <= '0;
        end
        slfb_pkg::ACT_PIX_LOAD: begin
          pix <= seg_clo[seg];
          rem <= seg_cnt[seg];
        end
        slfb_pkg::ACT_PIX_STEP: begin
          pix <= pix + slfb_pkg::BYTE_W'(1);
          rem <= rem - slfb_pkg::CNT_W'(1);
        end
        slfb_pkg::ACT_SEG_STEP: seg <= seg + slfb_pkg::SEG_W'(1);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ctrl.uw.src)
      slfb_pkg::SRC_LIT:   out_byte = ctrl.uw.lit;
      slfb_pkg::SRC_NSEG:  out_byte = slfb_pkg::BYTE_W'(nseg);
      slfb_pkg::SRC_RED:   out_byte = slfb_pkg::seg_colour(red, seg, slfb_pkg::FULL);
      slfb_pkg::SRC_GREEN: out_byte = slfb_pkg::seg_colour(green, seg, slfb_pkg::ZERO_BYTE);
      slfb_pkg::SRC_BLUE:  out_byte = slfb_pkg::seg_colour(blue, seg, slfb_pkg::ZERO_BYTE);
      slfb_pkg::SRC_COUNT: out_byte = slfb_pkg::BYTE_W'(seg_cnt[seg]);
      slfb_pkg::SRC_PIXEL: out_byte = pix;
      default:             out_byte = ctrl.uw.lit;
    endcase
    out_last = (ctrl.uw.src == slfb_pkg::SRC_PIXEL) && (rem == slfb_pkg::CNT_W'(1)) &&
               (seg == last_seg);
  end

  assign status.in_valid  = s_tvalid;
  assign status.frame     = (mode == slfb_pkg::MODE_FRAME);
  assign status.seg_empty = (seg_cnt[seg] == '0);
  assign status.pix_more  = (rem > slfb_pkg::CNT_W'(1));
  assign status.seg_more  = (seg != slfb_pkg::SEG_W'(NUM_SEGS - 1));

endmodule

// ===== rtl/core/steering_led_frame_builder.sv =====
// Top level of the steering LED frame builder: sequencer, datapath and output register.
//
// Input stream (s_*): one word per event. s_tuser carries the event kind
// (angle update, distance report, millisecond tick, frame request); s_tdata
// carries the angle and the distance. Angle, distance and tick words are
// taken while the sequencer stays on its accept step. A frame request
// produces an LED command frame of 27 to 46 bytes on the output stream (m_*),
// one byte per word, m_tlast on the final byte. Besides the byte steps, a
// frame needs four setup steps (colour, reciprocal multiply, correction,
// segment bounds) plus two control steps per segment. The next input word
// is taken only once the frame is fully handed to the output register. When
// the receiver stalls, the byte in the output register holds and the
// sequencer waits on its emit step; nothing is lost. Reset (rst, synchronous)
// loads the register defaults, clears the stored angle and close flag and
// saturates the hold timer. The cfg port writes one register per cycle; the user
// must use it only while no frame is in progress; the block does not enforce it.
module steering_led_frame_builder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [1:0]                  s_tuser,   // [1:0] mode
  input  logic [31:0]                 s_tdata,   // [15:0] angle_mrad, [31:16] distance_cm
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [slfb_pkg::BYTE_W-1:0] m_tdata,   // [7:0] frame_byte
  output logic                        m_tlast,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [slfb_pkg::CFG_W-1:0]  cfg_data
);

  slfb_pkg::ctrl_t             ctrl;
  slfb_pkg::dp_status_t        status;
  logic                        out_free;
  logic                        out_load;
  logic [slfb_pkg::BYTE_W-1:0] out_byte;
  logic                        out_last;

  assign out_free = !m_tvalid || m_tready;
  assign out_load = ctrl.go && ctrl.uw.emit;

  slfb_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .status   (status),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  slfb_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_byte;
      m_tlast <= out_last;
    end
  end

endmodule
